>>> hw/rtl/dhfk_pkg.sv
// shared types, constants and tables for the dh chain forward kinematics unit
package dhfk_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int CORDIC_STEPS = 24;
   localparam int LEN_W = 26;
   localparam int ANGLE_W = 16;
   localparam int ENTRY_W = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 26;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ENABLE = 1'd1;
   localparam logic [LEN_W-1:0] LINK_LENGTH_RESET = 26'd8192000;
   localparam logic signed [63:0] CORDIC_X0 = 64'sd652032874;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle_cdeg;
      logic last_joint;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] row_index;
      logic [1:0] column_index;
      logic signed [ENTRY_W-1:0] entry_value;
      logic last_entry;
   } rsp_payload_type;

   // atan(2^-i) in hundredths of a degree times 2^16
   function automatic logic signed [31:0] atan_lookup(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0: v = 32'sd294912000;
         5'd1: v = 32'sd174096719;
         5'd2: v = 32'sd91987925;
         5'd3: v = 32'sd46694507;
         5'd4: v = 32'sd23437865;
         5'd5: v = 32'sd11730358;
         5'd6: v = 32'sd5866610;
         5'd7: v = 32'sd2933484;
         5'd8: v = 32'sd1466764;
         5'd9: v = 32'sd733385;
         5'd10: v = 32'sd366693;
         5'd11: v = 32'sd183346;
         5'd12: v = 32'sd91673;
         5'd13: v = 32'sd45837;
         5'd14: v = 32'sd22918;
         5'd15: v = 32'sd11459;
         5'd16: v = 32'sd5730;
         5'd17: v = 32'sd2865;
         5'd18: v = 32'sd1432;
         5'd19: v = 32'sd716;
         5'd20: v = 32'sd358;
         5'd21: v = 32'sd179;
         5'd22: v = 32'sd90;
         5'd23: v = 32'sd45;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [ENTRY_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [ENTRY_W-1:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[ENTRY_W-1:0];
      return r;
   endfunction

endpackage

>>> hw/rtl/dhfk_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
module dhfk_cordic #(
   parameter int FRAC_BITS = dhfk_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [dhfk_pkg::ANGLE_W-1:0] angle,
   output logic done,
   output logic signed [dhfk_pkg::ENTRY_W-1:0] cos_out,
   output logic signed [dhfk_pkg::ENTRY_W-1:0] sin_out
);
   localparam int RSH = 30 - FRAC_BITS;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (RSH - 1);

   logic signed [63:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [4:0] step_ff, step_in;
   logic busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic signed [17:0] a_w;
   logic signed [63:0] xs, ys, xr, yr;
   logic signed [33:0] at;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
      logic signed [63:0] r;
      if (v >= 0) r = (v + HALF) >>> RSH;
      else r = -((-v + HALF) >>> RSH);
      return r;
   endfunction

   always_comb begin
      a_w = 18'(angle);
      // wrap into [-180, 180) degrees first
      if (a_w >= 18'sd18000) a_w = a_w - 18'sd36000;
      else if (a_w < -18'sd18000) a_w = a_w + 18'sd36000;
      neg_in = neg_ff;
      if (a_w > 18'sd9000) begin
         a_w = a_w - 18'sd18000;
         neg_in = 1'b1;
      end else if (a_w < -18'sd9000) begin
         a_w = a_w + 18'sd18000;
         neg_in = 1'b1;
      end else begin
         neg_in = 1'b0;
      end
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      at = 34'(dhfk_pkg::atan_lookup(step_ff));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in = dhfk_pkg::CORDIC_X0;
         y_in = '0;
         z_in = 34'(a_w) <<< 16;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         neg_in = neg_ff;
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(dhfk_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         neg_in = neg_ff;
      end
      xr = rnd(x_ff);
      yr = rnd(y_ff);
      cos_out = neg_ff ? -xr[31:0] : xr[31:0];
      sin_out = neg_ff ? -yr[31:0] : yr[31:0];
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      step_ff <= step_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

>>> hw/rtl/dh_chain_forward_kinematics_unit.sv
// top level: joint transform chain with shared cordic and shared multiplier
// per joint: an accept step, the cordic rotation, 2 link-offset multiplies and 36 matrix
// multiplies (12 entries x 3 terms, one 32x32 multiply each)
// a last joint adds a base step and 12 output entries, held while the result side stalls
// one joint is in work at a time, so no new joint is taken before the last one is through
// synchronous active-high reset loads the identity, even parity and default registers
module dh_chain_forward_kinematics_unit #(
   parameter int FRAC_BITS = dhfk_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  dhfk_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output dhfk_pkg::rsp_payload_type rsp_payload,
   input  logic csr_write_enable,
   input  logic [dhfk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dhfk_pkg::CSR_DATA_W-1:0] csr_write_data
);
   localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam int LEN_LSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int LEN_RSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int LEN_HALF_SH = (LEN_RSH > 0) ? LEN_RSH - 1 : 0;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_TRIG = 6'b000010,
      ST_MAC  = 6'b000100,
      ST_BASE = 6'b001000,
      ST_OUT  = 6'b010000,
      ST_LEN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [dhfk_pkg::LEN_W-1:0] link_length_ff;
   logic base_enable_ff;
   logic signed [31:0] tf_ff [12];
   logic signed [31:0] nt_ff [12];
   logic parity_ff, twist_ff, last_ff;
   logic signed [31:0] c_ff, s_ff, lc_ff, ls_ff;
   logic [3:0] idx_ff;   // entry index r*4+j
   logic [1:0] k_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] lenfix;
   logic cdone;
   logic signed [31:0] ccos, csin;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod, prod_r;
   logic signed [31:0] mk;
   logic [1:0] row, col;
   logic signed [63:0] acc_next;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
      logic signed [63:0] r;
      if (v >= 0) r = (v + HALF) >>> FRAC_BITS;
      else r = -((-v + HALF) >>> FRAC_BITS);
      return r;
   endfunction

   function automatic logic signed [63:0] len_conv(input logic [25:0] l);
      logic signed [63:0] v;
      v = 64'(l) <<< LEN_LSH;
      if (LEN_RSH > 0) v = (v + (64'sd1 <<< LEN_HALF_SH)) >>> LEN_RSH;
      return 64'(dhfk_pkg::sat32(v));
   endfunction

   dhfk_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
      .clock(clock), .reset(reset),
      .start(state_ff == ST_IDLE && req_valid),
      .angle(req_payload.angle_cdeg),
      .done(cdone), .cos_out(ccos), .sin_out(csin)
   );

   assign lenfix = len_conv(link_length_ff);
   assign row = idx_ff[3:2];
   assign col = idx_ff[1:0];

   // element m[k][col] of the joint matrix
   always_comb begin
      mk = '0;
      if (!parity_ff) begin
         case ({k_ff, col})
            4'b0000: mk = c_ff;
            4'b0010: mk = twist_ff ? -s_ff : s_ff;
            4'b0100: mk = s_ff;
            4'b0110: mk = twist_ff ? c_ff : -c_ff;
            4'b1001: mk = twist_ff ? -ONE[31:0] : ONE[31:0];
            default: mk = '0;
         endcase
      end else begin
         case ({k_ff, col})
            4'b0000: mk = c_ff;
            4'b0001: mk = -s_ff;
            4'b0011: mk = lc_ff;
            4'b0100: mk = s_ff;
            4'b0101: mk = c_ff;
            4'b0111: mk = ls_ff;
            4'b1010: mk = ONE[31:0];
            default: mk = '0;
         endcase
      end
   end

   // shared multiplier
   always_comb begin
      if (state_ff == ST_LEN) begin
         mul_a = lenfix[31:0];
         mul_b = k_ff[0] ? s_ff : c_ff;
      end else begin
         mul_a = tf_ff[{row, k_ff}];
         mul_b = mk;
      end
      prod = 64'(mul_a) * 64'(mul_b);
      prod_r = rnd(prod);
      acc_next = acc_ff + prod_r;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_TRIG;
         ST_TRIG: if (cdone) state_in = ST_LEN;
         ST_LEN:  if (k_ff == 2'd1) state_in = ST_MAC;
         ST_MAC:  if (k_ff == 2'd2 && idx_ff == 4'd11)
                     state_in = last_ff ? ST_BASE : ST_IDLE;
         ST_BASE: state_in = ST_OUT;
         ST_OUT:  if (!rsp_stall && idx_ff == 4'd11) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   always_comb begin
      rsp_payload.row_index = row;
      rsp_payload.column_index = col;
      rsp_payload.entry_value = tf_ff[idx_ff];
      rsp_payload.last_entry = (idx_ff == 4'd11);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         link_length_ff <= dhfk_pkg::LINK_LENGTH_RESET;
         base_enable_ff <= 1'b1;
         parity_ff <= 1'b0;
         twist_ff <= 1'b0;
         idx_ff <= '0;
         k_ff <= '0;
         for (int i = 0; i < 12; i++)
            tf_ff[i] <= (i == 0 || i == 5 || i == 10) ? ONE[31:0] : 32'sd0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            if (csr_index == dhfk_pkg::CSR_LINK_LENGTH) link_length_ff <= csr_write_data;
            else if (csr_index == dhfk_pkg::CSR_BASE_ENABLE)
               base_enable_ff <= csr_write_data[0];
         end
         case (state_ff)
            ST_IDLE: begin
               last_ff <= req_payload.last_joint;
               idx_ff <= '0;
               k_ff <= '0;
               acc_ff <= '0;
               if (req_valid && !parity_ff) twist_ff <= ~twist_ff;
            end
            ST_TRIG: begin
               c_ff <= ccos;
               s_ff <= csin;
            end
            ST_LEN: begin
               if (k_ff[0]) ls_ff <= prod_r[31:0];
               else lc_ff <= prod_r[31:0];
               k_ff <= k_ff[0] ? 2'd0 : 2'd1;
            end
            ST_MAC: begin
               if (k_ff == 2'd2) begin
                  nt_ff[idx_ff] <= dhfk_pkg::sat32(col == 2'd3 ?
                     acc_next + 64'(tf_ff[idx_ff]) : acc_next);
                  acc_ff <= '0;
                  k_ff <= '0;
                  if (idx_ff == 4'd11) begin
                     idx_ff <= '0;
                     parity_ff <= ~parity_ff;
                     for (int i = 0; i < 11; i++) tf_ff[i] <= nt_ff[i];
                     tf_ff[11] <= dhfk_pkg::sat32(acc_next + 64'(tf_ff[11]));
                  end else begin
                     idx_ff <= idx_ff + 4'd1;
                  end
               end else begin
                  acc_ff <= acc_next;
                  k_ff <= k_ff + 2'd1;
               end
            end
            ST_BASE: begin
               if (base_enable_ff) tf_ff[3] <= dhfk_pkg::sat32(64'(tf_ff[3]) + lenfix);
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  if (idx_ff == 4'd11) begin
                     idx_ff <= '0;
                     parity_ff <= 1'b0;
                     twist_ff <= 1'b0;
                     for (int i = 0; i < 12; i++)
                        tf_ff[i] <= (i == 0 || i == 5 || i == 10) ? ONE[31:0] : 32'sd0;
                  end else begin
                     idx_ff <= idx_ff + 4'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end
endmodule
